// ===== rtl/partition_fit_allocator_core_assert.svh =====
// assertion macros used by the partition fit allocator core
`ifndef PARTITION_FIT_ALLOCATOR_CORE_ASSERT_SVH
`define PARTITION_FIT_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication
`define PFA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the next cycle
`define PFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// invariant at every edge out of reset
`define PFA_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) 1'b1 |-> (cond)) \
    else $error(msg);

`endif

// ===== rtl/pfa_pkg.sv =====
// types, constants and helpers for the partition fit allocator
package pfa_pkg;

  localparam int MAX_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int ACC_W      = SIZE_BITS + IDX_W;

  // fixed port widths
  localparam int MODE_W     = 2;
  localparam int BINDEX_W   = 4;
  localparam int AMOUNT_W   = 16;
  localparam int CHOSEN_W   = 4;
  localparam int SUM_W      = 20;
  localparam int BCOUNT_W   = 5;
  localparam int POLICY_W   = 2;
  localparam int APB_DW     = 32;
  localparam int APB_AW     = 3;
  localparam int EXT_W      = (ACC_W > SUM_W) ? ACC_W : SUM_W;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RESTART = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd2;

  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_COUNT  = 1'b1;

  localparam logic [BCOUNT_W-1:0] COUNT_RESET = BCOUNT_W'(16);

  typedef enum logic [POLICY_W-1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_NEXT  = 2'd2,
    POL_WORST = 2'd3
  } policy_t;

  // scan record handed from cell to cell
  typedef struct packed {
    logic                 alloc;
    policy_t              policy;
    logic [CNT_W-1:0]     count;
    logic [IDX_W-1:0]     start;
    logic [SIZE_BITS-1:0] req;
    logic                 found;
    logic [IDX_W-1:0]     sel;
    logic [SIZE_BITS-1:0] best;
    logic                 hi_found;
    logic [IDX_W-1:0]     hi_sel;
    logic [ACC_W-1:0]     rsum;
    logic [ACC_W-1:0]     isum;
  } probe_t;

  // table update broadcast to every cell
  typedef struct packed {
    logic                 load;
    logic                 restart;
    logic                 sub;
    logic [IDX_W-1:0]     index;
    logic [SIZE_BITS-1:0] amount;
  } cmd_t;

  function automatic logic [SUM_W-1:0] sat_sum(input logic [ACC_W-1:0] a);
    logic [EXT_W-1:0] e;
    e = EXT_W'(a);
    if (e > EXT_W'(SUM_MAX)) begin
      return SUM_MAX;
    end
    return SUM_W'(e);
  endfunction

endpackage

// ===== rtl/partition_fit_allocator_core.sv =====
// partition fit allocator: chain of partition cells, item handshake and apb registers
//
// usage
//   item channel (item_valid/item_ready): mode, block_index, amount. mode load
//   sets one partition's size, restart restores all remaining sizes and clears
//   the next-fit pointer, allocate places a request under fit_policy.
//   result channel (result_valid/result_ready): granted, chosen_block,
//   free_total, total_memory; exactly one result beat per item beat.
//   apb port: register 0 fit_policy at 0x0, register 1 block_count at 0x4.
//   write registers only while no item is in flight.
// timing
//   one item at a time. a scan record walks the row of MAX_BLOCKS cells, one
//   cell per cycle, is held by the finishing stage and is then loaded into the
//   output register; the next item can be taken once that result is loaded.
//   the result sits in an output register, so a new item is taken while the
//   previous result still waits; a stalled receiver only holds back the
//   finishing stage, and with it item_ready, until that result is taken.
// reset
//   synchronous rst clears all sizes, the next-fit pointer, fit_policy to first
//   fit and block_count to 16.
module partition_fit_allocator_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  logic [pfa_pkg::MODE_W-1:0]     mode,
  input  logic [pfa_pkg::BINDEX_W-1:0]   block_index,
  input  logic [pfa_pkg::AMOUNT_W-1:0]   amount,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic                           granted,
  output logic [pfa_pkg::CHOSEN_W-1:0]   chosen_block,
  output logic [pfa_pkg::SUM_W-1:0]      free_total,
  output logic [pfa_pkg::SUM_W-1:0]      total_memory,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pfa_pkg::APB_AW-1:0]     paddr,
  input  logic [pfa_pkg::APB_DW-1:0]     pwdata,
  output logic [pfa_pkg::APB_DW-1:0]     prdata,
  output logic                           pready
);
  import pfa_pkg::*;

  `include "partition_fit_allocator_core_assert.svh"

  policy_t              fit_policy;
  logic [BCOUNT_W-1:0]  block_count;
  logic [IDX_W-1:0]     ptr;
  logic                 busy;
  logic                 seed_v;
  probe_t               seed;
  logic                 pend;
  probe_t               fin;

  logic                 accept;
  logic                 cfg_wr;
  logic [CNT_W-1:0]     n_use;
  logic [IDX_W-1:0]     start;
  logic                 ld_ok;
  logic                 fin_go;
  logic                 fin_grant;
  logic [IDX_W-1:0]     fin_pick;
  logic [ACC_W-1:0]     fin_free;
  cmd_t                 cmd;
  probe_t               seed_next;

  logic [MAX_BLOCKS:0]  pv;
  probe_t               pr [MAX_BLOCKS+1];

  // apb registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy  <= POL_FIRST;
      block_count <= COUNT_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_POLICY: fit_policy  <= policy_t'(pwdata[POLICY_W-1:0]);
        REG_COUNT:  block_count <= pwdata[BCOUNT_W-1:0];
        default:    fit_policy  <= fit_policy;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_POLICY: prdata = APB_DW'(fit_policy);
      REG_COUNT:  prdata = APB_DW'(block_count);
      default:    prdata = '0;
    endcase
  end

  // partitions in use and next-fit start
  always_comb begin
    if (block_count == '0) begin
      n_use = CNT_W'(1);
    end else if (32'(block_count) > MAX_BLOCKS) begin
      n_use = CNT_W'(MAX_BLOCKS);
    end else begin
      n_use = CNT_W'(block_count);
    end
  end

  assign start = (CNT_W'(ptr) < n_use) ? ptr : '0;
  assign ld_ok = (32'(block_index) < MAX_BLOCKS);

  // item handshake
  assign item_ready = !busy;
  assign accept     = item_valid && item_ready;

  always_comb begin
    seed_next          = '0;
    seed_next.alloc    = (mode == MODE_ALLOC);
    seed_next.policy   = fit_policy;
    seed_next.count    = n_use;
    seed_next.start    = start;
    seed_next.req      = SIZE_BITS'(amount);
  end

  // finishing stage
  assign fin_go    = pend && (!result_valid || result_ready);
  assign fin_grant = fin.alloc && fin.found;
  assign fin_pick  = (fin.policy == POL_NEXT && fin.hi_found) ? fin.hi_sel : fin.sel;
  assign fin_free  = fin.rsum - (fin_grant ? ACC_W'(fin.req) : '0);

  // table updates: load and restart at the item beat, subtraction at finish
  always_comb begin
    cmd         = '0;
    cmd.load    = accept && (mode == MODE_LOAD) && ld_ok;
    cmd.restart = accept && (mode == MODE_RESTART);
    cmd.sub     = fin_go && fin_grant;
    if (cmd.sub) begin
      cmd.index  = fin_pick;
      cmd.amount = fin.req;
    end else begin
      cmd.index  = IDX_W'(block_index);
      cmd.amount = SIZE_BITS'(amount);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      seed_v       <= 1'b0;
      pend         <= 1'b0;
      result_valid <= 1'b0;
      ptr          <= '0;
    end else begin
      seed_v <= accept;
      if (accept) begin
        busy <= 1'b1;
      end else if (fin_go) begin
        busy <= 1'b0;
      end
      if (pv[MAX_BLOCKS]) begin
        pend <= 1'b1;
      end else if (fin_go) begin
        pend <= 1'b0;
      end
      if (fin_go) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (cmd.restart) begin
        ptr <= '0;
      end else if (fin_go && fin_grant && fin.policy == POL_NEXT) begin
        ptr <= fin_pick;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      seed <= seed_next;
    end
    if (pv[MAX_BLOCKS]) begin
      fin <= pr[MAX_BLOCKS];
    end
    if (fin_go) begin
      granted      <= fin_grant;
      chosen_block <= fin_grant ? CHOSEN_W'(fin_pick) : '0;
      free_total   <= sat_sum(fin_free);
      total_memory <= sat_sum(fin.isum);
    end
  end

  // row of partition cells
  assign pv[0] = seed_v;
  assign pr[0] = seed;

  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
    pfa_cell u_cell (
      .clk             (clk),
      .rst             (rst),
      .cell_index      (IDX_W'(g)),
      .cmd             (cmd),
      .probe_in_valid  (pv[g]),
      .probe_in        (pr[g]),
      .probe_out_valid (pv[g+1]),
      .probe_out       (pr[g+1])
    );
  end

  `PFA_ASSERT_ALWAYS(a_one_scan, clk, rst, $countones(pv) <= 1, "more than one scan in the row")
  `PFA_ASSERT_IMPL(a_pend_idle_row, clk, rst, pend, pv == '0, "scan active while result pending")
  `PFA_ASSERT_IMPL(a_refused_block, clk, rst, result_valid && !granted, chosen_block == '0, "refused beat names a block")
  `PFA_ASSERT_IMPL(a_granted_in_use, clk, rst, result_valid && granted, 32'(chosen_block) < 32'(n_use), "granted block not in use")
  `PFA_ASSERT_IMPL(a_free_le_total, clk, rst, result_valid, free_total <= total_memory, "free space exceeds total")

endmodule

// ===== rtl/pfa_cell.sv =====
// one partition: its sizes and one stage of the fit scan
module pfa_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [pfa_pkg::IDX_W-1:0]   cell_index,
  input  pfa_pkg::cmd_t               cmd,
  input  logic                        probe_in_valid,
  input  pfa_pkg::probe_t             probe_in,
  output logic                        probe_out_valid,
  output pfa_pkg::probe_t             probe_out
);
  import pfa_pkg::*;

  logic [SIZE_BITS-1:0] init_size;
  logic [SIZE_BITS-1:0] rem_size;
  logic                 hit;
  logic                 active;
  logic                 fits;
  probe_t               probe_next;

  assign hit = (cmd.index == cell_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      init_size <= '0;
      rem_size  <= '0;
    end else if (cmd.load && hit) begin
      init_size <= cmd.amount;
      rem_size  <= cmd.amount;
    end else if (cmd.restart) begin
      rem_size <= init_size;
    end else if (cmd.sub && hit) begin
      rem_size <= rem_size - cmd.amount;
    end
  end

  assign active = (CNT_W'(cell_index) < probe_in.count);
  assign fits   = active && (rem_size >= probe_in.req);

  always_comb begin
    probe_next = probe_in;
    if (active) begin
      probe_next.rsum = probe_in.rsum + ACC_W'(rem_size);
      probe_next.isum = probe_in.isum + ACC_W'(init_size);
    end
    case (probe_in.policy)
      POL_FIRST: begin
        if (fits && !probe_in.found) begin
          probe_next.found = 1'b1;
          probe_next.sel   = cell_index;
        end
      end
      POL_BEST: begin
        // ties go to the later block
        if (fits && (!probe_in.found || rem_size <= probe_in.best)) begin
          probe_next.found = 1'b1;
          probe_next.sel   = cell_index;
          probe_next.best  = rem_size;
        end
      end
      POL_WORST: begin
        if (fits && (!probe_in.found || rem_size >= probe_in.best)) begin
          probe_next.found = 1'b1;
          probe_next.sel   = cell_index;
          probe_next.best  = rem_size;
        end
      end
      POL_NEXT: begin
        // first fit overall covers the wrap, first fit at or after start wins
        if (fits && !probe_in.found) begin
          probe_next.found = 1'b1;
          probe_next.sel   = cell_index;
        end
        if (fits && !probe_in.hi_found && cell_index >= probe_in.start) begin
          probe_next.hi_found = 1'b1;
          probe_next.hi_sel   = cell_index;
        end
      end
      default: begin
        probe_next = probe_in;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out_valid <= 1'b0;
    end else begin
      probe_out_valid <= probe_in_valid;
    end
  end

  always_ff @(posedge clk) begin
    probe_out <= probe_next;
  end

endmodule

// ===== test/partition_fit_allocator_core_tb.sv =====
// testbench for the partition fit allocator core: fit predictor, item traffic and apb set-up
module partition_fit_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pfa_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_PHASES = 15;
  localparam int PHASE_ITEMS   = 88;

  typedef struct {
    logic                granted;
    logic [CHOSEN_W-1:0] chosen;
    logic [SUM_W-1:0]    free_kb;
    logic [SUM_W-1:0]    total_kb;
  } alloc_result_t;

  logic                clk;
  logic                rst;
  logic                item_valid;
  logic                item_ready;
  logic [MODE_W-1:0]   mode;
  logic [BINDEX_W-1:0] block_index;
  logic [AMOUNT_W-1:0] amount;
  logic                result_valid;
  logic                result_ready;
  logic                granted;
  logic [CHOSEN_W-1:0] chosen_block;
  logic [SUM_W-1:0]    free_total;
  logic [SUM_W-1:0]    total_memory;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  // predictor state, mirrors the partition table and the registers
  logic [SIZE_BITS-1:0] part_initial   [MAX_BLOCKS] = '{default: '0};
  logic [SIZE_BITS-1:0] part_remaining [MAX_BLOCKS] = '{default: '0};
  logic [IDX_W-1:0]     next_fit_idx = '0;
  policy_t              cfg_policy = POL_FIRST;
  logic [BCOUNT_W-1:0]  cfg_count = COUNT_RESET;

  alloc_result_t expected_results[$];
  int            mismatches = 0;
  int            gap_max = 6;
  int            stall_max = 6;
  int            cycle_count = 0;

  partition_fit_allocator_core dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int blocks_used();
    if (cfg_count == 0) return 1;
    if (cfg_count > MAX_BLOCKS) return MAX_BLOCKS;
    return int'(cfg_count);
  endfunction

  function automatic alloc_result_t predict_partition_result(
      input logic [MODE_W-1:0] m, input logic [BINDEX_W-1:0] idx,
      input logic [AMOUNT_W-1:0] amt);
    alloc_result_t r;
    int            n;
    int            start;
    int            c;
    int            j;
    int            pick;
    bit            found;
    logic [SUM_W:0] rsum;
    logic [SUM_W:0] isum;
    n = blocks_used();
    r.granted = 1'b0;
    r.chosen = '0;
    found = 1'b0;
    pick = 0;
    case (m)
      MODE_LOAD: begin
        part_initial[idx] = amt;
        part_remaining[idx] = amt;
      end
      MODE_RESTART: begin
        for (j = 0; j < MAX_BLOCKS; j++) part_remaining[j] = part_initial[j];
        next_fit_idx = '0;
      end
      MODE_ALLOC: begin
        if (cfg_policy == POL_NEXT) begin
          // a pointer beyond the blocks in use restarts the scan at block zero
          start = (int'(next_fit_idx) < n) ? int'(next_fit_idx) : 0;
          for (c = 0; c < n && !found; c++) begin
            j = start + c;
            if (j >= n) j -= n;
            if (part_remaining[j] >= amt) begin
              pick = j;
              found = 1'b1;
            end
          end
        end else begin
          for (j = 0; j < n; j++) begin
            if (part_remaining[j] >= amt && !(found && cfg_policy == POL_FIRST)) begin
              // ties go to the higher index for best and worst fit
              if (!found ||
                  (cfg_policy == POL_BEST && part_remaining[j] <= part_remaining[pick]) ||
                  (cfg_policy == POL_WORST && part_remaining[j] >= part_remaining[pick])) begin
                pick = j;
                found = 1'b1;
              end
            end
          end
        end
        if (found) begin
          part_remaining[pick] -= amt;
          if (cfg_policy == POL_NEXT) next_fit_idx = IDX_W'(pick);
          r.granted = 1'b1;
          r.chosen = CHOSEN_W'(pick);
        end
      end
      default: ;
    endcase
    rsum = '0;
    isum = '0;
    for (j = 0; j < n; j++) begin
      rsum += (SUM_W+1)'(part_remaining[j]);
      isum += (SUM_W+1)'(part_initial[j]);
    end
    r.free_kb = (rsum > SUM_MAX) ? SUM_MAX : rsum[SUM_W-1:0];
    r.total_kb = (isum > SUM_MAX) ? SUM_MAX : isum[SUM_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [SUM_W-1:0] want,
                             input logic [SUM_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // result side: random stall before each beat, then compare with the oldest prediction
  initial begin : result_sink
    int            stall;
    alloc_result_t want;
    result_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = $urandom_range(0, stall_max);
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, granted %0d block %0d",
                 $time, granted, chosen_block);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("granted", SUM_W'(want.granted), SUM_W'(granted));
        check_field("chosen_block", SUM_W'(want.chosen), SUM_W'(chosen_block));
        check_field("free_total", want.free_kb, free_total);
        check_field("total_memory", want.total_kb, total_memory);
      end
    end
  end

  task automatic send_item(input logic [MODE_W-1:0] m, input logic [BINDEX_W-1:0] idx,
                           input logic [AMOUNT_W-1:0] amt);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    mode <= m;
    block_index <= idx;
    amount <= amt;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    expected_results.push_back(predict_partition_result(m, idx, amt));
  endtask

  // hold the item side until every result is back, then let the scan settle
  task automatic wait_idle();
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [APB_DW-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_POLICY) cfg_policy = policy_t'(value[POLICY_W-1:0]);
    else cfg_count = value[BCOUNT_W-1:0];
    @(posedge clk);
  endtask

  // upper data bits are junk, only the register width is kept
  task automatic set_config(input policy_t pol, input int cnt);
    wait_idle();
    write_reg(REG_POLICY, (32'($urandom) & ~32'h3) | 32'(pol));
    write_reg(REG_COUNT, (32'($urandom) & ~32'h1F) | 32'(cnt));
  endtask

  task automatic test_directed_cases();
    set_config(POL_FIRST, 16);
    send_item(MODE_ALLOC, 4'd0, 16'd0);       // empty table still takes a zero request
    send_item(MODE_ALLOC, 4'd0, 16'd1);
    send_item(MODE_LOAD, 4'd15, 16'hFFFF);
    send_item(MODE_LOAD, 4'd0, 16'd0);
    send_item(MODE_LOAD, 4'd10, 16'hAAAA);
    send_item(MODE_LOAD, 4'd5, 16'h5555);
    send_item(MODE_LOAD, 4'd3, 16'h5555);
    send_item(MODE_UNUSED, 4'd15, 16'hFFFF);
    send_item(MODE_ALLOC, 4'd15, 16'h5555);   // first fit skips past block zero
    send_item(MODE_ALLOC, 4'd0, 16'hFFFF);    // exact fit empties block 15
    send_item(MODE_ALLOC, 4'd0, 16'hFFFF);    // no room left
    send_item(MODE_RESTART, 4'd7, 16'h1234);
    set_config(POL_BEST, 16);
    send_item(MODE_ALLOC, 4'd0, 16'h5000);    // equal sizes, higher index wins
    set_config(POL_WORST, 16);
    send_item(MODE_LOAD, 4'd14, 16'hFFFF);
    send_item(MODE_ALLOC, 4'd0, 16'd1);
    set_config(POL_NEXT, 16);
    send_item(MODE_RESTART, 4'd0, 16'd0);
    send_item(MODE_ALLOC, 4'd0, 16'h1000);
    send_item(MODE_ALLOC, 4'd0, 16'h5000);    // moves on from the block just used
    send_item(MODE_ALLOC, 4'd0, 16'h0555);    // scan starts at the last granted block
    set_config(POL_NEXT, 4);                   // pointer now beyond the blocks in use
    send_item(MODE_ALLOC, 4'd0, 16'd0);
    set_config(POL_FIRST, 0);                  // zero count behaves as one block
    send_item(MODE_ALLOC, 4'd0, 16'd0);
    send_item(MODE_LOAD, 4'd9, 16'd100);       // load outside the blocks in use
    set_config(POL_WORST, 31);                 // oversized count clamps to the table
    send_item(MODE_ALLOC, 4'd0, 16'd50);
  endtask

  task automatic send_random_item();
    int                  kind;
    int                  n;
    int                  b;
    logic [BINDEX_W-1:0] idx;
    logic [AMOUNT_W-1:0] amt;
    n = blocks_used();
    kind = $urandom_range(0, 99);
    b = $urandom_range(0, n - 1);
    idx = BINDEX_W'($urandom);
    if (kind < 14) begin
      case ($urandom_range(0, 4))
        0: amt = AMOUNT_W'($urandom);
        1: amt = AMOUNT_W'($urandom_range(0, 4095));
        2: amt = part_initial[$urandom_range(0, MAX_BLOCKS - 1)];   // repeats give ties
        3: amt = 16'hFFFF;
        default: amt = '0;
      endcase
      if ($urandom_range(0, 3) != 0) idx = BINDEX_W'(b);
      send_item(MODE_LOAD, idx, amt);
    end else if (kind < 18) begin
      send_item(MODE_RESTART, idx, AMOUNT_W'($urandom));
    end else if (kind < 21) begin
      send_item(MODE_UNUSED, idx, AMOUNT_W'($urandom));
    end else begin
      case ($urandom_range(0, 5))
        0: amt = part_remaining[b];
        1: amt = AMOUNT_W'($urandom_range(0, part_remaining[b]));
        2: amt = AMOUNT_W'($urandom_range(0, 1023));
        3: amt = AMOUNT_W'($urandom);
        4: amt = '0;
        default: amt = part_remaining[b] + 1'b1;
      endcase
      send_item(MODE_ALLOC, idx, amt);
    end
  endtask

  task automatic test_random_traffic();
    int phase;
    int k;
    int cnt;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase % 5)
        0: cnt = 16;
        1: cnt = 1;
        2: cnt = $urandom_range(2, 15);
        3: cnt = (phase % 2 != 0) ? 0 : $urandom_range(17, 31);
        default: cnt = $urandom_range(1, 16);
      endcase
      gap_max = (phase % 3 == 0) ? 0 : 6;
      stall_max = (phase % 4 == 1) ? 0 : 6;
      set_config(policy_t'(phase % 4), cnt);
      // refill the blocks in use so allocations have room to work with
      for (k = 0; k < blocks_used(); k++)
        send_item(MODE_LOAD, BINDEX_W'(k),
                  ($urandom_range(0, 2) == 0) ? AMOUNT_W'($urandom)
                                              : AMOUNT_W'($urandom_range(0, 8191)));
      for (k = 0; k < PHASE_ITEMS; k++) send_random_item();
    end
  endtask

  initial begin
    rst <= 1'b1;
    item_valid <= 1'b0;
    mode <= MODE_LOAD;
    block_index <= '0;
    amount <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_traffic();
    wait_idle();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
